FILE: rtl/dds_pkg.sv
// shared types, constants and command/status structs for the distributed delay stage
package dds_pkg;

    localparam int DEF_MAX_CLASSES  = 64;
    localparam int DEF_MAX_SUBSTEPS = 64;

    localparam logic [39:0] CAP40 = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [14:0] FULL_MORT = 15'd25600;

    // 25600 = 25 * 2^10; 2^24 = 25 * DIV25_WRAP + 16
    localparam logic [19:0] DIV25_WRAP  = 20'd671088;
    // ceil(2^31 / 25), exact floor divide by 25 for values below 2^26
    localparam logic [26:0] DIV25_RECIP = 27'd85899346;

    localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [1:0] REG_FLOW_RATE   = 2'd1;
    localparam logic [1:0] REG_ATTRITION   = 2'd2;
    localparam logic [1:0] REG_INIT_INFLOW = 2'd3;

    // per-class phases
    localparam logic [1:0] PH_READ  = 2'd0;  // memory read issued
    localparam logic [1:0] PH_OPER  = 2'd1;  // operand prep, or add for summing
    localparam logic [1:0] PH_MUL   = 2'd2;  // low half product
    localparam logic [1:0] PH_WRITE = 2'd3;  // high half product and write

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_LOAD     = 4'd1,  // latch tick inputs, add inflow, compute rate*dt
        OP_SURV     = 4'd2,  // survival scaling of one class
        OP_CLEAR    = 4'd3,  // zero one class
        OP_PROD     = 4'd4,  // b*rd and substep count
        OP_DIV      = 4'd5,  // one restoring step for rd/n and pend/n
        OP_OUTF     = 4'd6,  // collect outflow from last class
        OP_CLS      = 4'd7,  // update one class i>0
        OP_CLS0     = 4'd8,  // update class 0
        OP_SUBDONE  = 4'd9,  // close the tick's integration
        OP_SUM      = 4'd10, // add one class into contents
        OP_SUMINIT  = 4'd11  // contents = pending
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [9:0]  idx;
        logic        rd_req;   // issue memory read at idx
        logic [1:0]  phase;    // per-class phase, see PH_*
    } dp_cmd_t;

    typedef struct packed {
        logic        dt_zero;
        logic        mort_zero;
        logic        mort_full;
        logic [10:0] n;
    } dp_stat_t;

endpackage

FILE: rtl/distributed_delay_stage.sv
// Erlang distributed delay with attrition: one tick in, one result out, one tick in flight.
// After reset the class memory is cleared one entry per cycle, all MAX_CLASSES entries, before
// the first tick is taken. A tick first scales the k classes for survival under partial
// mortality, or clears the whole class memory under full mortality. With a nonzero time step a
// restoring divider then forms the per-substep rate and inflow, and the class memory is walked
// once per class per substep, in four phases per class for the split rate multiply; every tick
// ends by summing the classes into contents.
module distributed_delay_stage
    import dds_pkg::*;
#(
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int MAX_SUBSTEPS = DEF_MAX_SUBSTEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] inflow,
    input  logic [15:0] time_step,
    input  logic [14:0] mortality_percent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] outflow,
    output logic [39:0] contents,
    output logic [47:0] inflow_total,
    output logic [47:0] outflow_total,
    output logic        substeps_clipped
);

    logic [6:0]  class_count_reg;
    logic [23:0] flow_rate_reg;
    logic [17:0] attrition_reg;
    logic [39:0] init_inflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 7'd30;
            flow_rate_reg   <= 24'd19661;
            attrition_reg   <= 18'd65536;
            init_inflow_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLASS_COUNT: class_count_reg <= cfg_data[6:0];
                REG_FLOW_RATE:   flow_rate_reg   <= cfg_data[23:0];
                REG_ATTRITION:   attrition_reg   <= cfg_data[17:0];
                REG_INIT_INFLOW: init_inflow_reg <= cfg_data;
            endcase
        end
    end

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dds_ctrl #(.MAX_CLASSES(MAX_CLASSES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .class_count (class_count_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    dds_datapath #(.MAX_CLASSES(MAX_CLASSES), .MAX_SUBSTEPS(MAX_SUBSTEPS)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .flow_rate         (flow_rate_reg),
        .attrition_factor  (attrition_reg),
        .initial_inflow    (init_inflow_reg),
        .inflow            (inflow),
        .time_step         (time_step),
        .mortality_percent (mortality_percent),
        .outflow           (outflow),
        .contents          (contents),
        .inflow_total      (inflow_total),
        .outflow_total     (outflow_total),
        .substeps_clipped  (substeps_clipped)
    );

`ifndef NO_ASSERTIONS
    // a result never shows while the block takes a new tick
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and result overlap");
    // a transfer on the output returns the block to accepting ticks
    a_ret: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready) else $error("no return to idle");
    // accepting a tick ends readiness until its result is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("tick overlap");
`endif

endmodule

FILE: rtl/dds_datapath.sv
// datapath: class memory, shared multiplier path, divider and accumulators
module dds_datapath
    import dds_pkg::*;
#(
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int MAX_SUBSTEPS = DEF_MAX_SUBSTEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [23:0] flow_rate,
    input  logic [17:0] attrition_factor,
    input  logic [39:0] initial_inflow,
    input  logic [31:0] inflow,
    input  logic [15:0] time_step,
    input  logic [14:0] mortality_percent,
    output logic [39:0] outflow,
    output logic [39:0] contents,
    output logic [47:0] inflow_total,
    output logic [47:0] outflow_total,
    output logic        substeps_clipped
);

    localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [39:0] mem [MAX_CLASSES];
    logic [39:0] rdata_reg;
    logic [39:0] prev_reg;        // class i-1 value read alongside

    logic [14:0] mort_reg;
    logic [15:0] dt_reg;
    logic [39:0] rd_reg;
    logic [39:0] pend_reg;
    logic [47:0] in_sum_reg;
    logic [47:0] out_sum_reg;
    logic [39:0] outf_reg;
    logic [39:0] cont_reg;
    logic        clip_reg;
    logic        first_reg;
    logic [10:0] n_reg;
    logic [41:0] a_reg;
    logic [39:0] per_reg;
    logic [40:0] arem_reg;
    logic [40:0] prem_reg;
    logic [5:0]  dcnt_reg;
    logic [41:0] mop_reg;
    logic        ge_reg;
    logic [54:0] sp_reg;
    logic [60:0] lo_reg;

    logic [AW-1:0] addr;
    logic [AW-1:0] addr_m1;
    assign addr    = cmd.idx[AW-1:0];
    assign addr_m1 = addr - AW'(1);

    // read ports
    always_ff @(posedge clk)
    begin
        if (cmd.rd_req)
        begin
            rdata_reg <= mem[addr];
            prev_reg  <= mem[addr_m1];
        end
    end

    logic [57:0] bx_full;
    logic [41:0] bx;
    assign bx_full = rdata_reg * attrition_factor;
    assign bx      = bx_full[57:16];

    logic [54:0] surv_p;
    assign surv_p = rdata_reg * (FULL_MORT - mort_reg);

    logic        ge;
    logic [41:0] diff;
    logic [41:0] mop_next;
    assign ge       = 42'(prev_reg) >= bx;
    assign diff     = ge ? 42'(prev_reg) - bx : bx - 42'(prev_reg);
    assign mop_next = (cmd.op == OP_OUTF) ? 42'(rdata_reg) : ((cmd.op == OP_CLS) ? diff : bx);

    // floor(surv_p / 25600): drop 2^10, then divide by 25 in two pieces
    logic [44:0] sy;
    logic [20:0] sy_hi;
    logic [23:0] sy_lo;
    logic [25:0] sz;
    logic [52:0] sz_q;
    logic [40:0] sq_hi;
    logic [40:0] sq_sum;
    logic [39:0] surv_q;
    assign sy     = sp_reg[54:10];
    assign sy_hi  = sy[44:24];
    assign sy_lo  = sy[23:0];
    assign sz     = {1'b0, sy_hi, 4'd0} + {2'd0, sy_lo};
    assign sz_q   = sz * DIV25_RECIP;
    assign sq_hi  = sy_hi * DIV25_WRAP;
    assign sq_sum = sq_hi + 41'(sz_q[52:31]);
    assign surv_q = sq_sum[39:0];

    // floor(a*m/2^24) in two halves, a 40 x 21 bit product each: low half in PH_MUL, high in PH_WRITE
    logic [39:0] a40;
    logic [20:0] m_sel;
    logic [60:0] pp;
    logic [82:0] pfull;
    logic [63:0] mq;
    assign a40   = a_reg[39:0];
    assign m_sel = (cmd.phase == PH_WRITE) ? mop_reg[41:21] : mop_reg[20:0];
    assign pp    = a40 * m_sel;
    assign pfull = 83'({pp, 21'd0}) + 83'(lo_reg);
    assign mq    = 64'(pfull[82:24]);

    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_OPER)
        begin
            sp_reg  <= surv_p;
            ge_reg  <= ge;
            mop_reg <= mop_next;
        end
        if (cmd.phase == PH_MUL)
            lo_reg <= pp;
    end

    logic [40:0] x_plus;
    assign x_plus = 41'(rdata_reg) + 41'(mq[39:0]);

    logic [40:0] outf_sum;
    assign outf_sum = 41'(outf_reg) + 41'(mq[39:0]);

    logic [40:0] t0;
    assign t0 = 41'(rdata_reg) + 41'(per_reg);

    logic [39:0] wdata;
    logic        wen;
    always_comb
    begin
        wen   = 1'b0;
        wdata = '0;
        unique case (cmd.op)
            OP_SURV:
            begin
                wen   = (cmd.phase == PH_WRITE);
                wdata = surv_q;
            end
            OP_CLEAR:
            begin
                wen = 1'b1;
            end
            OP_CLS:
            begin
                wen = (cmd.phase == PH_WRITE);
                if (ge_reg)
                    wdata = (x_plus > 41'(CAP40) || mq[63:40] != 24'd0) ? CAP40 : x_plus[39:0];
                else
                    wdata = (mq >= 64'(rdata_reg)) ? 40'd0 : rdata_reg - mq[39:0];
            end
            OP_CLS0:
            begin
                wen = (cmd.phase == PH_WRITE);
                if (mq >= 64'(t0))
                    wdata = 40'd0;
                else
                    wdata = (64'(t0) - mq > 64'(CAP40)) ? CAP40 : 40'(64'(t0) - mq);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[addr] <= wdata;
    end

    // substep count from b*rd
    logic [57:0] prod;
    logic [59:0] nfull;
    assign prod  = {18'd0, rd_reg} * 58'(attrition_factor);
    assign nfull = ({1'b0, prod, 1'b0} + (60'd3 << 39)) >> 40;

    logic [40:0] add_in;
    logic [41:0] pend_sum;
    logic [48:0] isum_sum;
    assign add_in   = 41'(inflow) + (first_reg ? 41'(initial_inflow) : 41'd0);
    assign pend_sum = 42'(pend_reg) + 42'(add_in);
    assign isum_sum = 49'(in_sum_reg) + 49'(add_in);

    logic [48:0] osum_sum;
    assign osum_sum = 49'(out_sum_reg) + 49'(outf_reg);
    logic [40:0] cont_sum;
    assign cont_sum = 41'(cont_reg) + 41'(rdata_reg);

    // restoring divide step, divisor n
    logic [41:0] ad_try;
    logic [41:0] pd_try;
    logic [41:0] ar_sh;
    logic [41:0] pr_sh;
    assign ar_sh = {arem_reg, a_reg[41]};
    assign pr_sh = {prem_reg, per_reg[39]};
    assign ad_try = ar_sh - 42'(n_reg);
    assign pd_try = pr_sh - 42'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            in_sum_reg  <= '0;
            out_sum_reg <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            if (cmd.op == OP_LOAD)
            begin
                first_reg  <= 1'b0;
                pend_reg   <= pend_sum > 42'(CAP40) ? CAP40 : pend_sum[39:0];
                in_sum_reg <= isum_sum > 49'(CAP48) ? CAP48 : isum_sum[47:0];
            end
            if (cmd.op == OP_SUBDONE)
            begin
                pend_reg    <= '0;
                out_sum_reg <= osum_sum > 49'(CAP48) ? CAP48 : osum_sum[47:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                mort_reg <= mortality_percent;
                dt_reg   <= time_step;
                rd_reg   <= 40'(flow_rate * time_step);
                outf_reg <= '0;
                clip_reg <= 1'b0;
            end
            OP_PROD:
            begin
                if (nfull > 60'(MAX_SUBSTEPS))
                begin
                    n_reg    <= 11'(MAX_SUBSTEPS);
                    clip_reg <= 1'b1;
                end
                else if (nfull == 60'd0)
                    n_reg <= 11'd1;
                else
                    n_reg <= nfull[10:0];
                a_reg    <= {2'd0, rd_reg};
                per_reg  <= pend_reg;
                arem_reg <= '0;
                prem_reg <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV:
            begin
                // a holds 42 quotient bits, per 40; a shifts 42 times, per 40 times
                dcnt_reg <= dcnt_reg + 6'd1;
                if (ad_try[41])
                begin
                    arem_reg <= ar_sh[40:0];
                    a_reg    <= {a_reg[40:0], 1'b0};
                end
                else
                begin
                    arem_reg <= ad_try[40:0];
                    a_reg    <= {a_reg[40:0], 1'b1};
                end
                if (dcnt_reg >= 6'd2)
                begin
                    if (pd_try[41])
                    begin
                        prem_reg <= pr_sh[40:0];
                        per_reg  <= {per_reg[38:0], 1'b0};
                    end
                    else
                    begin
                        prem_reg <= pd_try[40:0];
                        per_reg  <= {per_reg[38:0], 1'b1};
                    end
                end
            end
            OP_OUTF:
            begin
                if (cmd.phase == PH_WRITE)
                    outf_reg <= (outf_sum > 41'(CAP40) || mq[63:40] != 24'd0)
                                ? CAP40 : outf_sum[39:0];
            end
            OP_SUMINIT:
            begin
                cont_reg <= pend_reg;
            end
            OP_SUM:
            begin
                if (cmd.phase == PH_OPER)
                    cont_reg <= cont_sum > 41'(CAP40) ? CAP40 : cont_sum[39:0];
            end
            default: ;
        endcase
    end

    assign stat.dt_zero   = (dt_reg == 16'd0);
    assign stat.mort_zero = (mort_reg == 15'd0);
    assign stat.mort_full = (mort_reg >= FULL_MORT);
    assign stat.n         = n_reg;

    assign outflow          = outf_reg;
    assign contents         = cont_reg;
    assign inflow_total     = in_sum_reg;
    assign outflow_total    = out_sum_reg;
    assign substeps_clipped = clip_reg;

endmodule

FILE: rtl/dds_ctrl.sv
// controller state machine sequencing survival, integration and summing
module dds_ctrl
    import dds_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [6:0] class_count,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_MORT  = 11'b00000000100,
        S_PROD  = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_OUTF  = 11'b00000100000,
        S_CLS   = 11'b00001000000,
        S_CLS0  = 11'b00010000000,
        S_DONE  = 11'b00100000000,
        S_SUM   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [9:0]  idx_reg, idx_next;
    logic [1:0]  ph_reg, ph_next;
    logic [10:0] sub_reg, sub_next;
    logic [9:0]  k;

    always_comb
    begin
        if (class_count == 7'd0)
            k = 10'd1;
        else if (32'(class_count) > MAX_CLASSES)
            k = 10'(MAX_CLASSES);
        else
            k = 10'(class_count);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        sub_next   = sub_reg;
        cmd        = '{op: OP_NOP, idx: idx_reg, rd_req: 1'b0, phase: ph_reg};
        unique case (state_reg)
            S_INIT:
            begin
                // clear the class memory once after reset
                cmd.op = OP_CLEAR;
                if (idx_reg == 10'(MAX_CLASSES - 1))
                begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                end
                else
                    idx_next = idx_reg + 10'd1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MORT;
                    idx_next   = '0;
                    ph_next    = PH_READ;
                end
            end
            S_MORT:
            begin
                if (stat.mort_full)
                begin
                    cmd.op = OP_CLEAR;
                    if (idx_reg == 10'(MAX_CLASSES - 1))
                        state_next = S_PROD;
                    else
                        idx_next = idx_reg + 10'd1;
                end
                else if (stat.mort_zero)
                    state_next = S_PROD;
                else
                begin
                    cmd.op     = OP_SURV;
                    cmd.rd_req = (ph_reg == PH_READ);
                    ph_next    = ph_reg + 2'd1;
                    if (ph_reg == PH_WRITE)
                    begin
                        if (idx_reg == k - 10'd1)
                            state_next = S_PROD;
                        else
                            idx_next = idx_reg + 10'd1;
                    end
                end
            end
            S_PROD:
            begin
                ph_next = PH_READ;
                if (stat.dt_zero)
                begin
                    state_next = S_SUM;
                    cmd.op     = OP_SUMINIT;
                    idx_next   = '0;
                end
                else
                begin
                    cmd.op     = OP_PROD;
                    state_next = S_DIV;
                    idx_next   = '0;
                end
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                idx_next = idx_reg + 10'd1;
                if (idx_reg == 10'd41)
                begin
                    state_next = S_OUTF;
                    idx_next   = k - 10'd1;
                    sub_next   = '0;
                end
            end
            S_OUTF:
            begin
                cmd.op     = OP_OUTF;
                cmd.rd_req = (ph_reg == PH_READ);
                ph_next    = ph_reg + 2'd1;
                if (ph_reg == PH_WRITE)
                    state_next = (k == 10'd1) ? S_CLS0 : S_CLS;
                if (ph_reg == PH_WRITE && k == 10'd1)
                    idx_next = '0;
            end
            S_CLS:
            begin
                cmd.op     = OP_CLS;
                cmd.rd_req = (ph_reg == PH_READ);
                ph_next    = ph_reg + 2'd1;
                if (ph_reg == PH_WRITE)
                begin
                    idx_next = idx_reg - 10'd1;
                    if (idx_reg == 10'd1)
                        state_next = S_CLS0;
                end
            end
            S_CLS0:
            begin
                cmd.op     = OP_CLS0;
                cmd.rd_req = (ph_reg == PH_READ);
                ph_next    = ph_reg + 2'd1;
                if (ph_reg == PH_WRITE)
                begin
                    idx_next = k - 10'd1;
                    sub_next = sub_reg + 11'd1;
                    state_next = (sub_reg + 11'd1 == stat.n) ? S_DONE : S_OUTF;
                end
            end
            S_DONE:
            begin
                cmd.op     = OP_SUBDONE;
                state_next = S_SUM;
                idx_next   = '0;
            end
            S_SUM:
            begin
                // first visit after DONE needs contents seeded from pending
                if (idx_reg == 10'd0 && ph_reg == PH_READ && sub_reg != 11'h7FF)
                begin
                    cmd.op   = OP_SUMINIT;
                    sub_next = 11'h7FF;
                end
                else
                begin
                    cmd.op     = OP_SUM;
                    cmd.rd_req = (ph_reg == PH_READ);
                    ph_next    = (ph_reg == PH_READ) ? PH_OPER : PH_READ;
                    if (ph_reg == PH_OPER)
                    begin
                        if (idx_reg == k - 10'd1)
                            state_next = S_OUT;
                        else
                            idx_next = idx_reg + 10'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_PROD && stat.dt_zero)
            sub_next = 11'h7FF;
        if (state_reg == S_DONE)
            sub_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            ph_reg    <= PH_READ;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the distributed delay stage: scoreboard against a tick predictor
`timescale 1ns / 1ps

module tb_top;
    import dds_pkg::*;

    typedef struct packed {
        logic [39:0] outflow;
        logic [39:0] contents;
        logic [47:0] inflow_total;
        logic [47:0] outflow_total;
        logic        clipped;
    } tick_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [39:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] inflow;
    logic [15:0] time_step;
    logic [14:0] mortality_percent;
    logic        out_valid;
    logic        out_ready;
    logic [39:0] outflow;
    logic [39:0] contents;
    logic [47:0] inflow_total;
    logic [47:0] outflow_total;
    logic        substeps_clipped;

    distributed_delay_stage dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .inflow(inflow),
        .time_step(time_step),
        .mortality_percent(mortality_percent),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .outflow(outflow),
        .contents(contents),
        .inflow_total(inflow_total),
        .outflow_total(outflow_total),
        .substeps_clipped(substeps_clipped)
    );

    // predictor state
    longint unsigned age_cls[DEF_MAX_CLASSES];
    longint unsigned pend_in;
    longint unsigned in_sum;
    longint unsigned out_sum;
    bit              first_tick;
    longint unsigned k_reg;
    longint unsigned rate_reg;
    longint unsigned atr_reg;
    longint unsigned init_reg;

    tick_result_t expected_ticks[$];
    int           err_count;
    int           burst_left;
    bit           gaps_on;
    int           hold_req;
    int           hold_cnt;
    int           ready_mode;
    int           mode_timer;
    int           pat_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned sat(longint unsigned v, longint unsigned cap);
        return (v > cap) ? cap : v;
    endfunction

    // floor(a*m / 2^24), exact
    function automatic longint unsigned mul_a(longint unsigned a, longint unsigned m);
        bit [127:0] p;
        p = 128'(a) * 128'(m);
        return 64'(p >> 24);
    endfunction

    function automatic tick_result_t predict_tick(bit [31:0] f, bit [15:0] dt, bit [14:0] mort);
        tick_result_t    r;
        longint unsigned c40, c48, k, add, outf, cont, rd, prod, n, a, per;
        longint unsigned bx, t, m, prev, x;
        bit              clip;
        c40  = longint'(CAP40);
        c48  = longint'(CAP48);
        k    = k_reg;
        outf = 0;
        clip = 1'b0;
        if (k < 1) k = 1;
        if (k > DEF_MAX_CLASSES) k = DEF_MAX_CLASSES;
        if (mort >= FULL_MORT)
        begin
            foreach (age_cls[i]) age_cls[i] = 0;
        end
        else if (mort != 0)
        begin
            for (int i = 0; i < k; i++)
                age_cls[i] = (age_cls[i] * (25600 - mort)) / 25600;
        end
        add = f;
        if (first_tick)
        begin
            add += init_reg;
            first_tick = 1'b0;
        end
        pend_in = sat(pend_in + add, c40);
        in_sum  = sat(in_sum + add, c48);
        if (dt != 0)
        begin
            rd   = rate_reg * dt;
            prod = atr_reg * rd;
            n    = (2 * prod + (64'd3 << 39)) >> 40;
            if (n > DEF_MAX_SUBSTEPS)
            begin
                n    = DEF_MAX_SUBSTEPS;
                clip = 1'b1;
            end
            if (n < 1) n = 1;
            a   = rd / n;
            per = pend_in / n;
            for (longint unsigned j = 0; j < n; j++)
            begin
                outf = sat(outf + mul_a(a, age_cls[k - 1]), c40);
                for (int i = int'(k) - 1; i > 0; i--)
                begin
                    prev = age_cls[i - 1];
                    x    = age_cls[i];
                    bx   = (x * atr_reg) >> 16;
                    if (prev >= bx)
                    begin
                        m = mul_a(a, prev - bx);
                        age_cls[i] = sat(x + m, c40);
                    end
                    else
                    begin
                        m = mul_a(a, bx - prev);
                        age_cls[i] = (m >= x) ? 0 : x - m;
                    end
                end
                bx = (age_cls[0] * atr_reg) >> 16;
                t  = age_cls[0] + per;
                m  = mul_a(a, bx);
                t  = (t > m) ? t - m : 0;
                age_cls[0] = sat(t, c40);
            end
            pend_in = 0;
            out_sum = sat(out_sum + outf, c48);
        end
        cont = pend_in;
        for (int i = 0; i < k; i++)
            cont = sat(cont + age_cls[i], c40);
        r.outflow       = outf[39:0];
        r.contents      = cont[39:0];
        r.inflow_total  = in_sum[47:0];
        r.outflow_total = out_sum[47:0];
        r.clipped       = clip;
        return r;
    endfunction

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_req > 0 && hold_cnt == 0)
            hold_cnt = hold_req;
        if (mode_timer == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_timer = $urandom_range(50, 600);
        end
        else
            mode_timer--;
        pat_cnt = (pat_cnt + 1) % 5;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (ready_mode == 0)
            out_ready <= 1'b1;
        else if (ready_mode == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= (pat_cnt != 0);
    end

    always @(posedge clk)
    begin
        if (hold_cnt > 0)
            hold_req <= 0;
    end

    // result checker
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                err_count++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (outflow !== want.outflow)
                begin
                    $display("%0t: outflow exp %h got %h", $time, want.outflow, outflow);
                    err_count++;
                end
                if (contents !== want.contents)
                begin
                    $display("%0t: contents exp %h got %h", $time, want.contents, contents);
                    err_count++;
                end
                if (inflow_total !== want.inflow_total)
                begin
                    $display("%0t: inflow_total exp %h got %h", $time, want.inflow_total,
                             inflow_total);
                    err_count++;
                end
                if (outflow_total !== want.outflow_total)
                begin
                    $display("%0t: outflow_total exp %h got %h", $time, want.outflow_total,
                             outflow_total);
                    err_count++;
                end
                if (substeps_clipped !== want.clipped)
                begin
                    $display("%0t: substeps_clipped exp %b got %b", $time, want.clipped,
                             substeps_clipped);
                    err_count++;
                end
            end
        end
    end

    task automatic send_tick(input bit [31:0] f, input bit [15:0] dt, input bit [14:0] mort);
        in_valid          <= 1'b1;
        inflow            <= f;
        time_step         <= dt;
        mortality_percent <= mort;
        do @(posedge clk); while (!in_ready);
        expected_ticks.push_back(predict_tick(f, dt, mort));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && gaps_on)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
    endtask

    // sender pause until every result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CLASS_COUNT: k_reg    = val[6:0];
            REG_FLOW_RATE:   rate_reg = val[23:0];
            REG_ATTRITION:   atr_reg  = val[17:0];
            REG_INIT_INFLOW: init_reg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [39:0] k, input logic [39:0] r, input logic [39:0] b);
        wait_idle();
        write_reg(REG_CLASS_COUNT, k);
        write_reg(REG_FLOW_RATE, r);
        write_reg(REG_ATTRITION, b);
    endtask

    task automatic test_directed();
        write_reg(REG_INIT_INFLOW, CAP40);
        send_tick(32'hFFFF_FFFF, 16'd0, 15'd0);
        send_tick(32'd0, 16'd256, 15'd0);
        send_tick(32'd0, 16'd256, 15'd100);
        send_tick(32'h0010_0000, 16'd256, FULL_MORT);
        send_tick(32'h03E8_0000, 16'd512, 15'd12800);
        send_tick(32'd0, 16'd0, 15'd0);
        send_tick(32'h0005_0000, 16'd1, 15'd1);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF);
        send_tick(32'h0100_0000, 16'hFFFF, 15'd0);
        send_tick(32'h0000_0001, 16'd64, 15'd25599);
        wait_idle();
        write_reg(REG_INIT_INFLOW, 40'd12345678);
        set_shape(40'd0, 40'd1, 40'd1);
        send_tick(32'h0002_0000, 16'd256, 15'd0);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 15'd0);
        set_shape(40'd0, 40'd0, 40'd0);
        send_tick(32'h0002_0000, 16'd300, 15'd0);
        send_tick(32'h0002_0000, 16'd0, 15'd10);
        set_shape(40'd127, 40'hFF_FFFF, 40'd131072);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 15'd0);
        send_tick(32'h1234_5678, 16'd1, 15'd0);
        set_shape(40'd64, 40'd19661, 40'd65536);
        send_tick(32'h0064_0000, 16'd256, 15'd0);
        send_tick(32'h0064_0000, 16'd256, 15'd5000);
        send_tick(32'd0, 16'd256, FULL_MORT);
    endtask

    task automatic test_backpressure();
        bit g;
        set_shape(40'd4, 40'd65536, 40'd65536);
        g        = gaps_on;
        gaps_on  = 1'b0;
        hold_req <= 3000;
        repeat (6)
            send_tick($urandom, 16'($urandom_range(1, 200)), 15'd0);
        gaps_on = g;
        wait_idle();
    endtask

    task automatic test_random(input int count);
        int    done;
        int    left;
        int    big;
        logic [15:0] dt;
        logic [14:0] mort;
        logic [31:0] f;
        done = 0;
        while (done < count)
        begin
            big = ($urandom_range(0, 9) == 0);
            if (big)
                set_shape(40'($urandom_range(40, 127)), 40'($urandom_range(1, 1 << 16)),
                          40'($urandom_range(1, 131072)));
            else
                set_shape(40'($urandom_range(0, 8)), 40'($urandom_range(0, 1 << 18)),
                          40'($urandom_range(0, 131072)));
            gaps_on = ($urandom_range(0, 3) != 0);
            left    = big ? 8 : $urandom_range(40, 120);
            repeat (left)
            begin
                case ($urandom_range(0, 9))
                    0: f = $urandom;
                    1: f = 32'hFFFF_FFFF;
                    2: f = 32'd0;
                    default: f = 32'($urandom_range(0, 32'h00FF_FFFF));
                endcase
                case ($urandom_range(0, 19))
                    0: dt = 16'd0;
                    1: dt = (big ? 16'($urandom_range(1, 64)) : 16'($urandom));
                    default: dt = 16'($urandom_range(1, big ? 64 : 600));
                endcase
                case ($urandom_range(0, 9))
                    0: mort = 15'($urandom);
                    1: mort = FULL_MORT;
                    2, 3: mort = 15'($urandom_range(1, 25599));
                    default: mort = 15'd0;
                endcase
                send_tick(f, dt, mort);
            end
            done += left;
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_CLASS_COUNT;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        inflow            <= '0;
        time_step         <= '0;
        mortality_percent <= '0;
        out_ready         <= 1'b0;
        hold_req          = 0;
        hold_cnt          = 0;
        ready_mode        = 0;
        mode_timer        = 0;
        pat_cnt           = 0;
        err_count         = 0;
        burst_left        = 4;
        gaps_on           = 1'b1;
        foreach (age_cls[i]) age_cls[i] = 0;
        pend_in    = 0;
        in_sum     = 0;
        out_sum    = 0;
        first_tick = 1'b1;
        k_reg      = 30;
        rate_reg   = 19661;
        atr_reg    = 65536;
        init_reg   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1370);
        wait_idle();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: distributed_delay_stage.f
rtl/dds_pkg.sv
rtl/dds_datapath.sv
rtl/dds_ctrl.sv
rtl/distributed_delay_stage.sv
verif/tb_top.sv
